// File: sv/tkst_pkg.sv
// Package for the top-k score table: request and response types, command codes,
// controller state type and the default table contents.
// No dependencies.
package tkst_pkg;

  localparam int unsigned MaxTableEntries = 10;
  localparam int unsigned DefaultCount = 10;

  typedef enum logic [1:0] {
    CMD_CHECK = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] score;
    logic [23:0]        entry_name;
    logic [3:0]         read_index;
  } tkst_req_t;

  typedef struct packed {
    logic               is_high_score;
    logic [3:0]         insert_position;
    logic               entry_valid;
    logic [23:0]        name_out;
    logic signed [31:0] score_out;
    logic               submitted_out;
  } tkst_rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } tkst_ctrl_t;

  function automatic logic [23:0] default_name(input int unsigned idx);
    logic [23:0] nm;
    case (idx)
      0: nm = 24'h425A52;
      1: nm = 24'h434446;
      2: nm = 24'h504B42;
      3: nm = 24'h464F4F;
      4: nm = 24'h424152;
      5: nm = 24'h42415A;
      6: nm = 24'h424147;
      7: nm = 24'h414243;
      8: nm = 24'h444546;
      9: nm = 24'h474849;
      default: nm = 24'h000000;
    endcase
    return nm;
  endfunction

  function automatic logic signed [31:0] default_score(input int unsigned idx);
    logic signed [31:0] sc;
    if (idx < DefaultCount) begin
      sc = 32'(1000 - 100 * idx);
    end else begin
      sc = '0;
    end
    return sc;
  endfunction

endpackage

// File: sv/top_k_score_table_unit.sv
// Top level of the top-k score table: controller and datapath.
// Depends on tkst_pkg, tkst_ctrl and tkst_datapath.
//
//   Channel   Ports                 Transaction
//   request   start, busy, req_i    accepted when start is high and busy is low
//   result    done_o, rsp_o         valid for the single cycle done_o is high
//
// A request is captured on the accepting edge, executed in the following cycle
// with every table cell comparing its score in parallel, and its result is shown
// in the cycle after that. A new request is taken only in the idle state, not
// while busy is high in the execute state. After reset the table holds the
// default entries at once. The receiver cannot stall results.
module top_k_score_table_unit #(
  parameter int unsigned MaxTableEntries = tkst_pkg::MaxTableEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tkst_pkg::tkst_req_t req_i,
  output tkst_pkg::tkst_rsp_t rsp_o,
  output logic                done_o
);
  import tkst_pkg::*;

  tkst_ctrl_t ctrl;

  tkst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  tkst_datapath #(
    .MaxTableEntries(MaxTableEntries)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule

// File: sv/tkst_ctrl.sv
// Controller state machine of the top-k score table.
// Depends on tkst_pkg for the state and command-bus types.
module tkst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output tkst_pkg::tkst_ctrl_t ctrl_o
);
  import tkst_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.load = start;
      end
      ST_EXEC: begin
        ctrl_o.exec = 1'b1;
        busy        = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/tkst_datapath.sv
// Datapath of the top-k score table: the row of table cells, the parallel score
// compare with insert shift, the read select and the result register. Depends on tkst_pkg.
module tkst_datapath #(
  parameter int unsigned MaxTableEntries = tkst_pkg::MaxTableEntries
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tkst_pkg::tkst_ctrl_t ctrl_i,
  input  tkst_pkg::tkst_req_t  req_i,
  output tkst_pkg::tkst_rsp_t  rsp_o,
  output logic                 done_o
);
  import tkst_pkg::*;

  localparam int unsigned CountWidth = $clog2(MaxTableEntries + 1);
  localparam int unsigned ResetCount =
      (MaxTableEntries < DefaultCount) ? MaxTableEntries : DefaultCount;

  tkst_req_t          req_q;
  logic [23:0]        name_q  [MaxTableEntries];
  logic [23:0]        name_d  [MaxTableEntries];
  logic signed [31:0] score_q [MaxTableEntries];
  logic signed [31:0] score_d [MaxTableEntries];
  logic               sub_q   [MaxTableEntries];
  logic               sub_d   [MaxTableEntries];
  logic [CountWidth-1:0] count_q, count_d;
  tkst_rsp_t          rsp_q, rsp_d;
  logic               done_q;

  logic [MaxTableEntries-1:0] ge;
  logic [CountWidth-1:0]      pos;
  logic signed [31:0]         last_score;
  logic                       hit;
  logic                       do_insert;
  logic [23:0]                rd_name;
  logic signed [31:0]         rd_score;
  logic                       rd_sub;

  always_comb begin
    for (int i = 0; i < MaxTableEntries; i++) begin
      ge[i] = (32'(i) < 32'(count_q)) && (score_q[i] >= req_q.score);
    end
  end

  always_comb begin
    pos = CountWidth'(MaxTableEntries);
    for (int i = MaxTableEntries - 1; i >= 0; i--) begin
      if (!ge[i]) begin
        pos = CountWidth'(i);
      end
    end
  end

  always_comb begin
    last_score = '0;
    rd_name    = '0;
    rd_score   = '0;
    rd_sub     = 1'b0;
    for (int i = 0; i < MaxTableEntries; i++) begin
      if (32'(i + 1) == 32'(count_q)) begin
        last_score = score_q[i];
      end
      if (32'(req_q.read_index) == 32'(i)) begin
        rd_name  = name_q[i];
        rd_score = score_q[i];
        rd_sub   = sub_q[i];
      end
    end
  end

  assign hit = (32'(count_q) < 32'(MaxTableEntries)) ||
               ((count_q != '0) && (last_score < req_q.score));

  always_comb begin
    rsp_d     = '0;
    do_insert = 1'b0;
    unique case (req_q.command)
      CMD_CHECK: rsp_d.is_high_score = hit;
      CMD_ADD: begin
        rsp_d.insert_position = 4'(pos);
        do_insert = (32'(pos) != 32'(MaxTableEntries));
      end
      CMD_READ: begin
        if (32'(req_q.read_index) < 32'(count_q)) begin
          rsp_d.entry_valid   = 1'b1;
          rsp_d.name_out      = rd_name;
          rsp_d.score_out     = rd_score;
          rsp_d.submitted_out = rd_sub;
        end
      end
      default: rsp_d = '0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < MaxTableEntries; i++) begin
      name_d[i]  = name_q[i];
      score_d[i] = score_q[i];
      sub_d[i]   = sub_q[i];
    end
    if (ctrl_i.exec && do_insert) begin
      if (!ge[0]) begin
        name_d[0]  = req_q.entry_name;
        score_d[0] = req_q.score;
        sub_d[0]   = 1'b0;
      end
      for (int i = 1; i < MaxTableEntries; i++) begin
        if (!ge[i]) begin
          if (ge[i-1]) begin
            name_d[i]  = req_q.entry_name;
            score_d[i] = req_q.score;
            sub_d[i]   = 1'b0;
          end else begin
            name_d[i]  = name_q[i-1];
            score_d[i] = score_q[i-1];
            sub_d[i]   = sub_q[i-1];
          end
        end
      end
      if (32'(count_q) < 32'(MaxTableEntries)) begin
        count_d = count_q + CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxTableEntries; i++) begin
        name_q[i]  <= default_name(i);
        score_q[i] <= default_score(i);
        sub_q[i]   <= (i < DefaultCount);
      end
      count_q <= CountWidth'(ResetCount);
      done_q  <= 1'b0;
    end else begin
      for (int i = 0; i < MaxTableEntries; i++) begin
        name_q[i]  <= name_d[i];
        score_q[i] <= score_d[i];
        sub_q[i]   <= sub_d[i];
      end
      count_q <= count_d;
      done_q  <= ctrl_i.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= req_i;
    end
    if (ctrl_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

// File: verif/tb_top_k_score_table_unit.sv
// Self-checking testbench for the top-k score table unit: directed and random
// check, add and read transactions, scored against a behavioral table kept here.
// Depends on tkst_pkg and top_k_score_table_unit.
module tb_top_k_score_table_unit;
  import tkst_pkg::*;

  localparam int unsigned TableDepth = MaxTableEntries;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles = 8;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [23:0] ResetNames [10] = '{
    24'h425A52, 24'h434446, 24'h504B42, 24'h464F4F, 24'h424152,
    24'h42415A, 24'h424147, 24'h414243, 24'h444546, 24'h474849
  };

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      start;
  logic      busy;
  logic      done_o;
  tkst_req_t req_i;
  tkst_rsp_t rsp_o;

  logic [23:0]        board_names [TableDepth];
  logic signed [31:0] board_scores [TableDepth];
  logic               board_submitted [TableDepth];
  int unsigned        board_count;
  tkst_rsp_t          pending_rsp_q [$];
  int unsigned        error_count = 0;
  int unsigned        idle_cycles = 0;
  bit                 no_gaps = 1'b0;

  top_k_score_table_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic reset_board();
    for (int unsigned i = 0; i < TableDepth; i++) begin
      if (i < 10) begin
        board_names[i]     = ResetNames[i];
        board_scores[i]    = 32'(1000 - 100 * i);
        board_submitted[i] = 1'b1;
      end else begin
        board_names[i]     = '0;
        board_scores[i]    = '0;
        board_submitted[i] = 1'b0;
      end
    end
    board_count = (TableDepth < 10) ? TableDepth : 10;
  endtask

  function automatic tkst_rsp_t score_table_apply(input tkst_req_t r);
    tkst_rsp_t   e;
    int unsigned pos;
    int unsigned last;
    e = '0;
    case (r.command)
      CMD_CHECK: begin
        e.is_high_score = (board_count < TableDepth) ||
                          (board_count > 0 &&
                           board_scores[board_count - 1] < $signed(r.score));
      end
      CMD_ADD: begin
        pos = 0;
        for (int unsigned i = 0; i < board_count; i++) begin
          if (board_scores[i] >= $signed(r.score)) pos++;
        end
        if (pos >= TableDepth) begin
          e.insert_position = 4'(TableDepth);
        end else begin
          last = (board_count < TableDepth) ? board_count : TableDepth - 1;
          for (int unsigned i = last; i > pos; i--) begin
            board_names[i]     = board_names[i - 1];
            board_scores[i]    = board_scores[i - 1];
            board_submitted[i] = board_submitted[i - 1];
          end
          board_names[pos]     = r.entry_name;
          board_scores[pos]    = r.score;
          board_submitted[pos] = 1'b0;
          if (board_count < TableDepth) board_count++;
          e.insert_position = 4'(pos);
        end
      end
      CMD_READ: begin
        if (r.read_index < board_count) begin
          e.entry_valid   = 1'b1;
          e.name_out      = board_names[r.read_index];
          e.score_out     = board_scores[r.read_index];
          e.submitted_out = board_submitted[r.read_index];
        end
      end
      default: begin
      end
    endcase
    return e;
  endfunction

  function automatic tkst_req_t make_item(input logic [1:0] cmd, input logic [31:0] sc,
                                          input logic [23:0] nm, input logic [3:0] idx);
    tkst_req_t r;
    r.command    = cmd;
    r.score      = sc;
    r.entry_name = nm;
    r.read_index = idx;
    return r;
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (no_gaps || sel < 50) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic tkst_req_t make_random_item();
    tkst_req_t   r;
    int unsigned sel;
    int unsigned kind;
    r.entry_name = 24'($urandom);
    r.read_index = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, TableDepth - 1))
                                              : 4'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 35) r.command = CMD_ADD;
    else if (sel < 65) r.command = CMD_READ;
    else if (sel < 95) r.command = CMD_CHECK;
    else r.command = CmdUnused;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      r.score = board_scores[$urandom_range(0, TableDepth - 1)] +
                32'($urandom_range(0, 2)) - 32'd1;
    end else if (kind < 8) begin
      r.score = $urandom;
    end else if (kind == 8) begin
      r.score = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end else begin
      r.score = $urandom_range(0, 2000);
    end
    return r;
  endfunction

  task automatic send_item(input tkst_req_t item, input int unsigned gap);
    if (!start) start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_rsp_q = {pending_rsp_q, score_table_apply(item)};
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    if (start) start <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin
    tkst_rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(rsp_o.insert_position), '0);
      end else begin
        want = pending_rsp_q.pop_front();
        check_field("is_high_score", 32'(rsp_o.is_high_score), 32'(want.is_high_score));
        check_field("insert_position", 32'(rsp_o.insert_position),
                    32'(want.insert_position));
        check_field("entry_valid", 32'(rsp_o.entry_valid), 32'(want.entry_valid));
        check_field("name_out", 32'(rsp_o.name_out), 32'(want.name_out));
        check_field("score_out", rsp_o.score_out, want.score_out);
        check_field("submitted_out", 32'(rsp_o.submitted_out), 32'(want.submitted_out));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("tb_top_k_score_table_unit: FAIL");
    $finish;
  end

  task automatic test_reset_contents();
    for (int unsigned i = 0; i < TableDepth; i++) begin
      send_item(make_item(CMD_READ, $urandom, 24'($urandom), 4'(i)), rand_gap());
    end
    send_item(make_item(CMD_READ, '0, '0, 4'(TableDepth)), rand_gap());
    send_item(make_item(CMD_READ, '1, '1, 4'hF), rand_gap());
  endtask

  task automatic test_qualify_check();
    send_item(make_item(CMD_CHECK, 32'd100, '0, '0), rand_gap());
    send_item(make_item(CMD_CHECK, 32'd101, '0, '0), rand_gap());
    send_item(make_item(CMD_CHECK, 32'h7FFF_FFFF, '1, '1), rand_gap());
    send_item(make_item(CMD_CHECK, 32'h8000_0000, '0, '0), rand_gap());
    send_item(make_item(CMD_CHECK, 32'hFFFF_FFFF, '0, '0), rand_gap());
  endtask

  task automatic test_insert_edges();
    send_item(make_item(CMD_ADD, 32'h7FFF_FFFF, 24'hFFFFFF, '0), rand_gap());
    send_item(make_item(CMD_ADD, 32'h8000_0000, 24'h000000, '0), rand_gap());
    send_item(make_item(CMD_ADD, 32'd500, 24'h414141, '0), rand_gap());
    send_item(make_item(CMD_ADD, 32'd500, 24'h424242, '0), rand_gap());
    send_item(make_item(CMD_ADD, 32'd200, 24'h434343, '0), rand_gap());
    send_item(make_item(CMD_READ, '0, '0, 4'd0), rand_gap());
    send_item(make_item(CMD_READ, '0, '0, 4'd6), rand_gap());
    send_item(make_item(CMD_READ, '0, '0, 4'd7), rand_gap());
    send_item(make_item(CMD_READ, '0, '0, 4'(TableDepth - 1)), rand_gap());
  endtask

  task automatic test_unused_command();
    send_item(make_item(CmdUnused, '1, '1, '1), rand_gap());
  endtask

  task automatic test_random_traffic(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_item(make_random_item(), rand_gap());
      if (n % 150 == 149) wait_for_results();
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    no_gaps = 1'b1;
    for (int unsigned n = 0; n < count; n++) begin
      send_item(make_random_item(), 0);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    reset_board();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_contents();
    test_qualify_check();
    test_insert_edges();
    test_unused_command();
    wait_for_results();
    test_random_traffic(700);
    test_back_to_back(250);
    test_random_traffic(600);
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top_k_score_table_unit: PASS");
    end else begin
      $display("tb_top_k_score_table_unit: FAIL");
    end
    $finish;
  end

endmodule
